/* hdl/tfd_pkg.sv */
// Shared constants, codes and interface types of the distance frame filter.
`default_nettype none

package tfd_pkg;

   // Frame layout
   localparam int FRAME_BYTES       = 16;
   localparam int SENSOR_COUNT      = 2;
   localparam int BYTE_POS_W        = $clog2(FRAME_BYTES);
   localparam int FRAME_STORE_DEPTH = SENSOR_COUNT * FRAME_BYTES;

   localparam logic [7:0]  HDR_BYTE0    = 8'h57;
   localparam logic [7:0]  HDR_BYTE1    = 8'h00;
   localparam logic [7:0]  HDR_BYTE2    = 8'hFF;
   localparam logic [23:0] OUT_OF_RANGE = 24'hFFFFF6;

   localparam logic [BYTE_POS_W-1:0] POS_ID       = BYTE_POS_W'(3);
   localparam logic [BYTE_POS_W-1:0] POS_DIST_LO  = BYTE_POS_W'(8);
   localparam logic [BYTE_POS_W-1:0] POS_DIST_MID = BYTE_POS_W'(9);
   localparam logic [BYTE_POS_W-1:0] POS_DIST_HI  = BYTE_POS_W'(10);
   localparam logic [BYTE_POS_W-1:0] POS_STR_LO   = BYTE_POS_W'(12);
   localparam logic [BYTE_POS_W-1:0] POS_STR_HI   = BYTE_POS_W'(13);
   localparam logic [BYTE_POS_W-1:0] POS_LAST     = BYTE_POS_W'(FRAME_BYTES - 1);

   // Filter sizing
   localparam int FILTER_TAPS = 8;
   localparam int DIST_W      = 24;
   localparam int STRENGTH_W  = 16;
   localparam int WEIGHT_SUM  = FILTER_TAPS * (FILTER_TAPS + 1) / 2;
   localparam int WGT_W       = $clog2(FILTER_TAPS + 1);
   localparam int WSUM_W      = $clog2(WEIGHT_SUM + 1);
   localparam int ACC_W       = DIST_W + WSUM_W;
   localparam int HPOS_W      = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
   localparam int HIST_DEPTH  = SENSOR_COUNT * FILTER_TAPS;
   localparam int HIST_ADDR_W = $clog2(HIST_DEPTH);

   // Rounded-up reciprocal of the weight sum; exact for every accumulator value.
   localparam int RECIP_SHIFT = ACC_W + WSUM_W;
   localparam int RECIP_W     = ACC_W + 2;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((longint'(1) << RECIP_SHIFT)
      + longint'(WEIGHT_SUM) - 1) / longint'(WEIGHT_SUM));

   // Frame status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD     = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // Register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_ID = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_ID  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET   = 2'd2;

   typedef struct packed {
      logic              start;
      logic              slot;
      logic [DIST_W-1:0] value;
   } tfd_flt_req_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] average;
   } tfd_flt_rsp_type;

endpackage

`default_nettype wire

/* hdl/tfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tfd_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/tfd_filter.sv */
// Per-sensor distance history in RAM with a weighted moving average unit.
`default_nettype none

module tfd_filter import tfd_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire tfd_flt_req_type flt_req,
   output      tfd_flt_rsp_type flt_rsp
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_TAPS,
      F_DIVIDE
   } fstate_type;

   fstate_type                fstate_ff;
   logic [HPOS_W-1:0]         hpos_ff [SENSOR_COUNT];
   logic [HIST_DEPTH-1:0]     hvalid_ff;
   logic                      slot_ff;
   logic [HPOS_W-1:0]         tap_ff;
   logic [WGT_W-1:0]          weight_ff;
   logic [WGT_W-1:0]          mac_w_ff;
   logic                      mac_vld_ff;
   logic                      valid_rd_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic                      done_ff;

   logic                      wr_en;
   logic [HIST_ADDR_W-1:0]    wr_addr;
   logic [HIST_ADDR_W-1:0]    rd_addr;
   logic [DIST_W-1:0]         rd_data;
   logic [DIST_W-1:0]         tap_val;
   logic [DIST_W+WGT_W-1:0]   product;
   logic [ACC_W+RECIP_W-1:0]  scaled;

   function automatic logic [HIST_ADDR_W-1:0] hist_addr(input logic slot,
                                                        input logic [HPOS_W-1:0] pos);
      logic [HIST_ADDR_W-1:0] a;
      a = HIST_ADDR_W'(pos);
      if (slot) begin
         a = a + HIST_ADDR_W'(FILTER_TAPS);
      end
      return a;
   endfunction

   assign wr_en   = flt_req.start && (fstate_ff == F_IDLE);
   assign wr_addr = hist_addr(flt_req.slot, hpos_ff[flt_req.slot]);
   assign rd_addr = hist_addr(slot_ff, tap_ff);

   tfd_ram #(
      .DEPTH(HIST_DEPTH),
      .WIDTH(DIST_W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (flt_req.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entries never written since reset read as zero.
   assign tap_val = valid_rd_ff ? rd_data : '0;
   assign product = (DIST_W+WGT_W)'(tap_val) * (DIST_W+WGT_W)'(mac_w_ff);

   // The upper bits of this product are the truncated quotient by the weight sum.
   assign scaled = (ACC_W+RECIP_W)'(acc_ff) * (ACC_W+RECIP_W)'(RECIP);

   always_ff @(posedge clock) begin
      valid_rd_ff <= hvalid_ff[rd_addr];
      if (reset) begin
         fstate_ff  <= F_IDLE;
         hvalid_ff  <= '0;
         mac_vld_ff <= 1'b0;
         weight_ff  <= '0;
         done_ff    <= 1'b0;
         for (int s = 0; s < SENSOR_COUNT; s++) begin
            hpos_ff[s] <= '0;
         end
      end else begin
         done_ff <= 1'b0;
         case (fstate_ff)
            F_IDLE: begin
               if (flt_req.start) begin
                  hvalid_ff[wr_addr] <= 1'b1;
                  if (hpos_ff[flt_req.slot] == HPOS_W'(FILTER_TAPS - 1)) begin
                     hpos_ff[flt_req.slot] <= '0;
                  end else begin
                     hpos_ff[flt_req.slot] <= hpos_ff[flt_req.slot] + 1'b1;
                  end
                  slot_ff    <= flt_req.slot;
                  tap_ff     <= hpos_ff[flt_req.slot];
                  weight_ff  <= WGT_W'(FILTER_TAPS);
                  mac_vld_ff <= 1'b0;
                  acc_ff     <= '0;
                  fstate_ff  <= F_TAPS;
               end
            end
            F_TAPS: begin
               // Newest sample first with the largest weight, walking backwards.
               if (weight_ff != '0) begin
                  mac_w_ff   <= weight_ff;
                  mac_vld_ff <= 1'b1;
                  weight_ff  <= weight_ff - 1'b1;
                  if (tap_ff == '0) begin
                     tap_ff <= HPOS_W'(FILTER_TAPS - 1);
                  end else begin
                     tap_ff <= tap_ff - 1'b1;
                  end
               end else begin
                  mac_vld_ff <= 1'b0;
               end
               if (mac_vld_ff) begin
                  acc_ff <= acc_ff + ACC_W'(product);
               end
               if ((weight_ff == '0) && !mac_vld_ff) begin
                  fstate_ff <= F_DIVIDE;
               end
            end
            F_DIVIDE: begin
               acc_ff    <= ACC_W'(scaled[ACC_W+RECIP_W-1:RECIP_SHIFT]);
               done_ff   <= 1'b1;
               fstate_ff <= F_IDLE;
            end
            default: begin
               fstate_ff <= F_IDLE;
            end
         endcase
      end
   end

   assign flt_rsp.done    = done_ff;
   assign flt_rsp.average = acc_ff[DIST_W-1:0];

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      flt_req.start |-> (fstate_ff == F_IDLE))
      else $error("filter started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("filter done held longer than one cycle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (fstate_ff == F_IDLE))
      else $error("filter done while still busy");

endmodule

`default_nettype wire

/* hdl/tof_frame_distance_filter.sv */
// Top level: byte intake, frame store, frame checker and result register.
//
// Bytes from two UART channels are stored per channel in a 32-entry frame RAM.
// Ordinary bytes are taken back to back while no frame is being evaluated. The byte that
// completes a frame starts its evaluation and req_stall stays high until the status item
// is loaded into the output register: the frame is read back from the frame RAM and
// checked, then for a good frame the filter multiply-accumulates over the sensor history
// RAM, multiplies by the reciprocal of the weight sum and hands the average over; then
// the result is loaded once the output register is empty or its result is being taken.
// A waiting result does not block intake of the next frame's bytes.
// Configuration writes are taken whenever no frame is being evaluated.
`default_nettype none

module tof_frame_distance_filter import tfd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   req_rx_channel,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_frame_channel,
   output      logic [1:0]             rsp_frame_status,
   output      logic                   rsp_sensor_slot,
   output      logic [DIST_W-1:0]      rsp_raw_distance,
   output      logic [STRENGTH_W-1:0]  rsp_signal_strength,
   output      logic [DIST_W-1:0]      rsp_filtered_distance,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FILTER,
      ST_OUTPUT
   } state_type;

   localparam int FS_ADDR_W = $clog2(FRAME_STORE_DEPTH);

   state_type                 state_ff;
   logic [BYTE_POS_W-1:0]     byte_pos_ff [SENSOR_COUNT];
   logic [7:0]                front_id_ff;
   logic [7:0]                back_id_ff;
   logic signed [15:0]        offset_ff;

   logic                      ch_ff;
   logic [7:0]                last_byte_ff;
   logic [BYTE_POS_W-1:0]     scan_cnt_ff;
   logic [7:0]                sum_ff;
   logic                      hdr_ok_ff;
   logic [7:0]                id_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic [STRENGTH_W-1:0]     strength_ff;
   logic [1:0]                status_ff;
   logic                      slot_ff;
   logic [DIST_W-1:0]         filt_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_channel_ff;
   logic [1:0]                rsp_status_ff;
   logic                      rsp_slot_ff;
   logic [DIST_W-1:0]         rsp_raw_ff;
   logic [STRENGTH_W-1:0]     rsp_strength_ff;
   logic [DIST_W-1:0]         rsp_filt_ff;

   logic                      req_accept;
   logic                      csr_write;
   logic                      rsp_load;
   logic [BYTE_POS_W-1:0]     wr_pos;
   logic [FS_ADDR_W-1:0]      fs_wr_addr;
   logic [FS_ADDR_W-1:0]      fs_rd_addr;
   logic [7:0]                fs_rd_data;
   logic [BYTE_POS_W-1:0]     proc_idx;
   logic [1:0]                check_status;
   logic signed [DIST_W+1:0]  offs_sum;
   logic [DIST_W-1:0]         clamped;
   tfd_flt_req_type           flt_req;
   tfd_flt_rsp_type           flt_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_load   = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || !rsp_stall);

   assign wr_pos     = byte_pos_ff[req_rx_channel];
   assign fs_wr_addr = {req_rx_channel, wr_pos};
   assign fs_rd_addr = {ch_ff, scan_cnt_ff};
   assign proc_idx   = scan_cnt_ff - 1'b1;

   tfd_ram #(
      .DEPTH(FRAME_STORE_DEPTH),
      .WIDTH(8)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (fs_wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (fs_rd_addr),
      .rd_data (fs_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < SENSOR_COUNT; c++) begin
            byte_pos_ff[c] <= '0;
         end
      end else if (req_accept) begin
         if (wr_pos == POS_LAST) begin
            byte_pos_ff[req_rx_channel] <= '0;
         end else begin
            byte_pos_ff[req_rx_channel] <= wr_pos + 1'b1;
         end
      end
   end

   // Offset, clamp at zero and saturate at the top of the 24-bit range.
   always_comb begin
      offs_sum = $signed({2'b00, dist_ff}) + (DIST_W+2)'(offset_ff);
      if (offs_sum[DIST_W+1]) begin
         clamped = '0;
      end else if (offs_sum[DIST_W]) begin
         clamped = '1;
      end else begin
         clamped = offs_sum[DIST_W-1:0];
      end

      if (!hdr_ok_ff || (sum_ff != last_byte_ff)) begin
         check_status = STATUS_BAD;
      end else if ((strength_ff == '0) || (dist_ff == OUT_OF_RANGE)) begin
         check_status = STATUS_RANGE;
      end else if ((id_ff != back_id_ff) && (id_ff != front_id_ff)) begin
         check_status = STATUS_UNKNOWN;
      end else begin
         check_status = STATUS_OK;
      end
   end

   assign flt_req.start = (state_ff == ST_CHECK) && (check_status == STATUS_OK);
   assign flt_req.slot  = (id_ff == back_id_ff);
   assign flt_req.value = clamped;

   tfd_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .flt_req (flt_req),
      .flt_rsp (flt_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         front_id_ff  <= 8'd0;
         back_id_ff   <= 8'd1;
         offset_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRONT_ID: front_id_ff <= csr_wdata[7:0];
               CSR_BACK_ID:  back_id_ff  <= csr_wdata[7:0];
               CSR_OFFSET:   offset_ff   <= $signed(csr_wdata);
               default:      ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (wr_pos == POS_LAST)) begin
                  ch_ff        <= req_rx_channel;
                  last_byte_ff <= req_rx_byte;
                  scan_cnt_ff  <= '0;
                  sum_ff       <= '0;
                  hdr_ok_ff    <= 1'b1;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Read data of the previous address arrives while the next is issued.
               if (scan_cnt_ff != '0) begin
                  sum_ff <= sum_ff + fs_rd_data;
                  case (proc_idx)
                     BYTE_POS_W'(0): hdr_ok_ff <= hdr_ok_ff && (fs_rd_data == HDR_BYTE0);
                     BYTE_POS_W'(1): hdr_ok_ff <= hdr_ok_ff && (fs_rd_data == HDR_BYTE1);
                     BYTE_POS_W'(2): hdr_ok_ff <= hdr_ok_ff && (fs_rd_data == HDR_BYTE2);
                     POS_ID:         id_ff     <= fs_rd_data;
                     POS_DIST_LO:    dist_ff[7:0]       <= fs_rd_data;
                     POS_DIST_MID:   dist_ff[15:8]      <= fs_rd_data;
                     POS_DIST_HI:    dist_ff[23:16]     <= fs_rd_data;
                     POS_STR_LO:     strength_ff[7:0]   <= fs_rd_data;
                     POS_STR_HI:     strength_ff[15:8]  <= fs_rd_data;
                     default:        ;
                  endcase
               end
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
               if (scan_cnt_ff == POS_LAST) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               status_ff <= check_status;
               filt_ff   <= '0;
               if (check_status == STATUS_OK) begin
                  slot_ff  <= flt_req.slot;
                  state_ff <= ST_FILTER;
               end else begin
                  slot_ff  <= 1'b0;
                  state_ff <= ST_OUTPUT;
               end
            end
            ST_FILTER: begin
               if (flt_rsp.done) begin
                  filt_ff  <= flt_rsp.average;
                  state_ff <= ST_OUTPUT;
               end
            end
            ST_OUTPUT: begin
               if (rsp_load) begin
                  rsp_channel_ff  <= ch_ff;
                  rsp_status_ff   <= status_ff;
                  rsp_slot_ff     <= slot_ff;
                  rsp_raw_ff      <= dist_ff;
                  rsp_strength_ff <= strength_ff;
                  rsp_filt_ff     <= filt_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_channel     = rsp_channel_ff;
   assign rsp_frame_status      = rsp_status_ff;
   assign rsp_sensor_slot       = rsp_slot_ff;
   assign rsp_raw_distance      = rsp_raw_ff;
   assign rsp_signal_strength   = rsp_strength_ff;
   assign rsp_filtered_distance = rsp_filt_ff;

   a_bad_frame_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
         (!rsp_slot_ff && (rsp_filt_ff == '0)))
      else $error("rejected frame carries a slot or filtered value");

   a_filter_done_expected: assert property (@(posedge clock) disable iff (reset)
      flt_rsp.done |-> (state_ff == ST_FILTER))
      else $error("filter answered while no frame was waiting for it");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(rsp_channel_ff) && $stable(rsp_status_ff) &&
          $stable(rsp_raw_ff) && $stable(rsp_filt_ff)))
      else $error("stalled result item changed");

endmodule

`default_nettype wire

/* sim/tb_tof_frame_distance_filter.sv */
// Self-checking testbench of the distance frame filter with driver, monitor and decoder.
module tb_tof_frame_distance_filter import tfd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES  = 1500;
   localparam int SETTLE_CYCLES = 80;
   localparam int TAIL_CYCLES   = 100;
   localparam int CYCLE_LIMIT   = 800_000;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

   typedef enum {FEED_BYTE, FEED_CSR, FEED_SETTLE} feed_kind_type;

   typedef enum {
      SHAPE_GOOD, SHAPE_BAD_HEADER, SHAPE_BAD_SUM, SHAPE_WEAK, SHAPE_FAR,
      SHAPE_STRANGER, SHAPE_JUNK
   } frame_shape_type;

   typedef struct {
      feed_kind_type          kind;
      logic [7:0]             rx;
      logic                   channel;
      logic [CSR_INDEX_W-1:0] index;
      logic [15:0]            wdata;
      int                     gap;
      bit                     stalls_on;
   } feed_entry_type;

   typedef struct {
      logic                  channel;
      logic [1:0]            status;
      logic                  slot;
      logic [DIST_W-1:0]     raw;
      logic [STRENGTH_W-1:0] strength;
      logic [DIST_W-1:0]     filtered;
   } frame_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte = '0;
   logic                   req_rx_channel = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_frame_channel;
   logic [1:0]             rsp_frame_status;
   logic                   rsp_sensor_slot;
   logic [DIST_W-1:0]      rsp_raw_distance;
   logic [STRENGTH_W-1:0]  rsp_signal_strength;
   logic [DIST_W-1:0]      rsp_filtered_distance;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_wdata = '0;

   tof_frame_distance_filter dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_rx_channel        (req_rx_channel),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_channel     (rsp_frame_channel),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_sensor_slot       (rsp_sensor_slot),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_signal_strength   (rsp_signal_strength),
      .rsp_filtered_distance (rsp_filtered_distance),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stimulus plan and handshake bookkeeping
   feed_entry_type   byte_feed [$];
   frame_report_type reports_due [$];
   logic [7:0]    lane0_q [$];
   logic [7:0]    lane1_q [$];
   int  fed_bytes = 0;
   int  bytes_sent = 0;
   int  bytes_taken = 0;
   int  csr_sent = 0;
   int  csr_taken = 0;
   int  hold_off = 0;
   int  stall_left = 0;
   bit  settling = 1'b0;
   bit  receiver_idles = 1'b1;
   int  mismatches = 0;
   int  cycle_count = 0;
   logic [7:0] plan_front = 8'd0;
   logic [7:0] plan_back = 8'd1;

   // Decoder state mirrored from the block
   frame_bytes_type   lane_frame [2];
   logic [3:0]        fill_pos [2];
   logic [DIST_W-1:0] history [2][FILTER_TAPS];
   int                hist_wr [2];
   logic [7:0]        front_id = 8'd0;
   logic [7:0]        back_id = 8'd1;
   logic signed [15:0] offset_reg = 16'sd0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] body_sum(input frame_bytes_type f);
      logic [7:0] s;
      s = '0;
      for (int k = 0; k < FRAME_BYTES - 1; k++) s = s + f[k];
      return s;
   endfunction

   function automatic frame_bytes_type reseal(input frame_bytes_type f);
      f[FRAME_BYTES-1] = body_sum(f);
      return f;
   endfunction

   function automatic frame_bytes_type shaped_frame(input frame_shape_type shape,
                                                    input logic [7:0] id,
                                                    input logic [DIST_W-1:0] distance,
                                                    input logic [STRENGTH_W-1:0] strength);
      frame_bytes_type f;
      int k;
      for (k = 0; k < FRAME_BYTES; k++) f[k] = 8'($urandom);
      if (shape != SHAPE_JUNK) begin
         f[0] = HDR_BYTE0;
         f[1] = HDR_BYTE1;
         f[2] = HDR_BYTE2;
         f[3] = id;
         {f[10], f[9], f[8]} = distance;
         {f[13], f[12]} = strength;
         if (shape == SHAPE_WEAK) {f[13], f[12]} = '0;
         if (shape == SHAPE_FAR) {f[10], f[9], f[8]} = OUT_OF_RANGE;
         if (shape == SHAPE_BAD_HEADER) begin
            k = $urandom_range(0, 2);
            f[k] = f[k] ^ 8'($urandom_range(1, 255));
         end
         f = reseal(f);
         if (shape == SHAPE_BAD_SUM) f[15] = f[15] ^ 8'($urandom_range(1, 255));
      end
      return f;
   endfunction

   function automatic logic [7:0] pick_id();
      int r;
      r = $urandom_range(0, 4);
      if (r == 0) return 8'h00;
      else if (r == 1) return 8'hFF;
      else return 8'($urandom);
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      else if (r == 1) return 24'hFFFFFF;
      else if (r < 4) return 24'($urandom_range(0, 40000));
      else if (r == 4) return 24'hFFFFFF - 24'($urandom_range(0, 40000));
      else return 24'($urandom);
   endfunction

   function automatic logic [STRENGTH_W-1:0] pick_strength();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0001;
      else if (r == 1) return 16'hFFFF;
      else return 16'($urandom);
   endfunction

   task automatic stage_frame(input frame_bytes_type f, input logic ch);
      for (int k = 0; k < FRAME_BYTES; k++) begin
         if (ch) lane1_q.push_back(f[k]);
         else lane0_q.push_back(f[k]);
      end
   endtask

   // Interleaves the staged bytes of both channels in random order.
   task automatic flush_lanes(input bit with_gaps);
      feed_entry_type e;
      logic ch;
      while (lane0_q.size() + lane1_q.size() > 0) begin
         if (lane0_q.size() == 0) ch = 1'b1;
         else if (lane1_q.size() == 0) ch = 1'b0;
         else ch = 1'($urandom_range(0, 1));
         e.kind = FEED_BYTE;
         e.channel = ch;
         e.rx = ch ? lane1_q.pop_front() : lane0_q.pop_front();
         e.gap = with_gaps ? pick_gap() : 0;
         byte_feed.push_back(e);
         fed_bytes++;
      end
   endtask

   task automatic queue_csr(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] wdata);
      feed_entry_type e;
      e.kind = FEED_CSR;
      e.index = index;
      e.wdata = wdata;
      e.gap = 0;
      byte_feed.push_back(e);
      if (index == CSR_FRONT_ID) plan_front = wdata[7:0];
      if (index == CSR_BACK_ID) plan_back = wdata[7:0];
   endtask

   // Waits for every outstanding result, then lets the block go quiet; also sets whether the result stall is driven.
   task automatic queue_settle(input bit stalls_on);
      feed_entry_type e;
      e.kind = FEED_SETTLE;
      e.gap = 0;
      e.stalls_on = stalls_on;
      byte_feed.push_back(e);
   endtask

   task automatic push_history(input logic slot, input logic [DIST_W-1:0] value,
                               output logic [DIST_W-1:0] average);
      logic [63:0] acc;
      int idx;
      history[slot][hist_wr[slot]] = value;
      hist_wr[slot] = (hist_wr[slot] + 1) % FILTER_TAPS;
      acc = '0;
      for (int i = 0; i < FILTER_TAPS; i++) begin
         idx = (hist_wr[slot] + 2 * FILTER_TAPS - 1 - i) % FILTER_TAPS;
         acc = acc + 64'(history[slot][idx]) * 64'(FILTER_TAPS - i);
      end
      average = DIST_W'(acc / 64'(WEIGHT_SUM));
   endtask

   task automatic absorb_rx_byte(input logic [7:0] rx, input logic ch);
      frame_report_type rep;
      frame_bytes_type f;
      int v;
      logic [DIST_W-1:0] clipped;
      lane_frame[ch][fill_pos[ch]] = rx;
      if (fill_pos[ch] != 4'(FRAME_BYTES - 1)) begin
         fill_pos[ch] = fill_pos[ch] + 4'd1;
      end else begin
         fill_pos[ch] = '0;
         f = lane_frame[ch];
         rep.channel = ch;
         rep.slot = 1'b0;
         rep.filtered = '0;
         rep.raw = {f[10], f[9], f[8]};
         rep.strength = {f[13], f[12]};
         if (f[0] != HDR_BYTE0 || f[1] != HDR_BYTE1 || f[2] != HDR_BYTE2 ||
             f[15] != body_sum(f)) begin
            rep.status = STATUS_BAD;
         end else if (rep.strength == '0 || rep.raw == OUT_OF_RANGE) begin
            rep.status = STATUS_RANGE;
         end else if (f[3] != front_id && f[3] != back_id) begin
            rep.status = STATUS_UNKNOWN;
         end else begin
            v = int'(rep.raw) + int'(offset_reg);
            if (v < 0) clipped = '0;
            else if (v > 16777215) clipped = 24'hFFFFFF;
            else clipped = DIST_W'(v);
            // The back history wins when both ids are equal.
            rep.slot = (f[3] == back_id);
            push_history(rep.slot, clipped, rep.filtered);
            rep.status = STATUS_OK;
         end
         reports_due.push_back(rep);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("cycle %0d: %s expected %0h, got %0h", cycle_count, name, want, got);
      end
   endtask

   // Drives bytes and register writes from the plan, and the result stall.
   always @(negedge clock) begin : feed_driver
      feed_entry_type e;
      logic next_req_valid;
      logic next_csr_valid;
      if (!reset) begin
         next_req_valid = req_valid && (bytes_taken != bytes_sent);
         next_csr_valid = csr_valid && (csr_taken != csr_sent);
         if (!next_req_valid && !next_csr_valid) begin
            if (settling) begin
               if (reports_due.size() == 0) begin
                  settling = 1'b0;
                  hold_off = SETTLE_CYCLES;
               end
            end else if (hold_off > 0) begin
               hold_off--;
            end else if (byte_feed.size() > 0) begin
               e = byte_feed.pop_front();
               hold_off = e.gap;
               case (e.kind)
                  FEED_BYTE: begin
                     next_req_valid = 1'b1;
                     req_rx_byte <= e.rx;
                     req_rx_channel <= e.channel;
                     bytes_sent++;
                  end
                  FEED_CSR: begin
                     next_csr_valid = 1'b1;
                     csr_index <= e.index;
                     csr_wdata <= e.wdata;
                     csr_sent++;
                  end
                  default: begin
                     settling = 1'b1;
                     receiver_idles = e.stalls_on;
                  end
               endcase
            end
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;

         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = receiver_idles ? pick_gap() : 0;
         end
      end
   end

   // Checks results first, then feeds accepted bytes and writes to the decoder.
   always @(posedge clock) begin : frame_monitor
      frame_report_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: result with nothing outstanding, channel %0d status %0d",
                           cycle_count, rsp_frame_channel, rsp_frame_status);
            end else begin
               want = reports_due.pop_front();
               compare_field("frame_channel", 32'(want.channel), 32'(rsp_frame_channel));
               compare_field("frame_status", 32'(want.status), 32'(rsp_frame_status));
               compare_field("sensor_slot", 32'(want.slot), 32'(rsp_sensor_slot));
               compare_field("raw_distance", 32'(want.raw), 32'(rsp_raw_distance));
               compare_field("signal_strength", 32'(want.strength), 32'(rsp_signal_strength));
               compare_field("filtered_distance", 32'(want.filtered),
                             32'(rsp_filtered_distance));
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            absorb_rx_byte(req_rx_byte, req_rx_channel);
         end
         if (csr_valid && csr_ready) begin
            csr_taken++;
            case (csr_index)
               CSR_FRONT_ID: front_id = csr_wdata[7:0];
               CSR_BACK_ID:  back_id = csr_wdata[7:0];
               CSR_OFFSET:   offset_reg = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tof_frame_distance_filter test failed");
         $finish;
      end
   end

   initial begin : stimulus
      frame_bytes_type f;
      frame_shape_type shape;
      logic [7:0] id;
      logic ch;
      bit calm;
      int r;
      int n;

      for (int s = 0; s < 2; s++) begin
         fill_pos[s] = '0;
         hist_wr[s] = 0;
         lane_frame[s] = '0;
         for (int t = 0; t < FILTER_TAPS; t++) history[s][t] = '0;
      end

      // Reset values of the registers: one of every frame outcome.
      stage_frame(shaped_frame(SHAPE_GOOD, 8'd0, 24'd1000, 16'h0001), 1'b0);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'd1, 24'hFFFFFF, 16'hFFFF), 1'b1);
      for (int k = 0; k < 3; k++) begin
         f = shaped_frame(SHAPE_GOOD, 8'd0, 24'd500, 16'd7);
         f[k] = ~f[k];
         stage_frame(reseal(f), k[0]);
      end
      stage_frame(shaped_frame(SHAPE_BAD_SUM, 8'd1, 24'd2000, 16'd9), 1'b1);
      stage_frame(shaped_frame(SHAPE_WEAK, 8'd0, 24'd3000, 16'd0), 1'b0);
      stage_frame(shaped_frame(SHAPE_FAR, 8'd1, OUT_OF_RANGE, 16'd40), 1'b1);
      stage_frame(shaped_frame(SHAPE_STRANGER, 8'd9, 24'd4000, 16'd40), 1'b0);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'd1, 24'd0, 16'h8000), 1'b1);
      flush_lanes(1'b1);

      // Most negative offset: small distances clamp to zero.
      queue_settle(1'b1);
      queue_csr(CSR_OFFSET, 16'h8000);
      queue_csr(CSR_FRONT_ID, 16'h00FF);
      queue_csr(CSR_BACK_ID, 16'hFF00);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'hFF, 24'd100, 16'd5), 1'b0);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'h00, 24'h008000, 16'd5), 1'b1);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'hFF, 24'hFFFFFF, 16'd5), 1'b0);
      flush_lanes(1'b0);

      // Most positive offset, equal ids and a write to the unused index.
      queue_settle(1'b0);
      queue_csr(CSR_OFFSET, 16'h7FFF);
      queue_csr(CSR_FRONT_ID, 16'h5A5A);
      queue_csr(CSR_BACK_ID, 16'h005A);
      queue_csr(2'd3, 16'hFFFF);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'h5A, 24'hFFFFF0, 16'd3), 1'b0);
      stage_frame(shaped_frame(SHAPE_GOOD, 8'h5A, 24'h123456, 16'd3), 1'b1);
      stage_frame(shaped_frame(SHAPE_STRANGER, 8'h00, 24'd77, 16'd3), 1'b1);
      flush_lanes(1'b1);

      while (fed_bytes < RANDOM_BYTES) begin
         calm = ($urandom_range(0, 3) == 0);
         queue_settle(!calm);
         if ($urandom_range(0, 1)) queue_csr(CSR_FRONT_ID, {8'($urandom), pick_id()});
         if ($urandom_range(0, 9) == 0) queue_csr(CSR_BACK_ID, {8'($urandom), plan_front});
         else if ($urandom_range(0, 1)) queue_csr(CSR_BACK_ID, {8'($urandom), pick_id()});
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 4);
            if (r == 0) queue_csr(CSR_OFFSET, 16'h8000);
            else if (r == 1) queue_csr(CSR_OFFSET, 16'h7FFF);
            else if (r == 2) queue_csr(CSR_OFFSET, 16'h0000);
            else queue_csr(CSR_OFFSET, 16'($urandom));
         end
         if ($urandom_range(0, 19) == 0) queue_csr(2'd3, 16'($urandom));

         n = $urandom_range(4, 12);
         for (int j = 0; j < n; j++) begin
            ch = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 70) shape = SHAPE_GOOD;
            else if (r < 75) shape = SHAPE_BAD_HEADER;
            else if (r < 80) shape = SHAPE_BAD_SUM;
            else if (r < 85) shape = SHAPE_WEAK;
            else if (r < 90) shape = SHAPE_FAR;
            else if (r < 95) shape = SHAPE_STRANGER;
            else shape = SHAPE_JUNK;
            if (shape == SHAPE_STRANGER) begin
               do id = 8'($urandom); while (id == plan_front || id == plan_back);
            end else begin
               id = $urandom_range(0, 1) ? plan_front : plan_back;
            end
            stage_frame(shaped_frame(shape, id, pick_distance(), pick_strength()), ch);
         end
         flush_lanes(!calm);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || req_valid || csr_valid || settling ||
             reports_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("tof_frame_distance_filter test passed");
      else
         $display("tof_frame_distance_filter test failed");
      $finish;
   end

endmodule

/* tof_frame_distance_filter.f */
hdl/tfd_pkg.sv
hdl/tfd_ram.sv
hdl/tfd_filter.sv
hdl/tof_frame_distance_filter.sv
sim/tb_tof_frame_distance_filter.sv
